// ===== src/cfd_pkg.sv =====
// Shared constants and types for the command frame deframer.
`default_nettype none

package cfd_pkg;

   localparam logic [7:0] HDR_FIRST   = 8'hAA;
   localparam logic [7:0] HDR_SECOND  = 8'hAF;
   localparam logic [7:0] FUNC_LIMIT  = 8'hF1;
   localparam logic [7:0] ACK_FUNC    = 8'hEF;
   localparam logic [7:0] ACK_LEN     = 8'h02;
   localparam logic [7:0] GROUP_LO    = 8'h10;
   localparam logic [7:0] GROUP_HI    = 8'h15;
   localparam logic [7:0] MAX_PAYLOAD = 8'd49;

   // Sum of the four fixed leading bytes of the acknowledgement.
   localparam logic [7:0] ACK_SUM_BASE = 8'(HDR_FIRST + HDR_FIRST + ACK_FUNC + ACK_LEN);

   // Byte positions within the acknowledgement frame.
   localparam logic [2:0] ACK_POS_HDR0 = 3'd0;
   localparam logic [2:0] ACK_POS_HDR1 = 3'd1;
   localparam logic [2:0] ACK_POS_FUNC = 3'd2;
   localparam logic [2:0] ACK_POS_LEN  = 3'd3;
   localparam logic [2:0] ACK_POS_CMD  = 3'd4;
   localparam logic [2:0] ACK_POS_CHK  = 3'd5;
   localparam logic [2:0] ACK_POS_SUM  = 3'd6;

   // Request from the parser to start an acknowledgement burst.
   typedef struct packed {
      logic       fire;
      logic [7:0] func;
      logic [7:0] check;
   } ack_req_type;

endpackage

`default_nettype wire

// ===== src/command_frame_deframer_with_ack.sv =====
// Top level of the command frame deframer with acknowledgement reply.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/stall     req_rx_byte[7:0]
//   rsp      out        rsp_valid/stall     rsp_tx_byte[7:0], rsp_tx_last
//
// A received request byte is parsed in the cycle it is accepted; the parser
// state registers take the update at that edge, so one byte can enter every cycle.
// A good checksum byte for a parameter-group function loads the sender, which
// presents the seven acknowledgement bytes one per cycle from its output register,
// unless stalled, starting in the cycle after the checksum byte is taken.
// While a reply is still going out, only a byte in the checksum position is held
// off; all other bytes keep flowing. That checksum byte waits until the last
// reply byte is taken, so a stalling receiver holds it off for as long as it
// stalls.
// Reset is synchronous and active high and returns the parser to header hunting.
`default_nettype none

module command_frame_deframer_with_ack
   import cfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_tx_last
);

   logic        at_check;
   logic        req_take;
   ack_req_type ack_req;

   // Only the checksum byte can start a new reply, so it alone waits for the
   // sender to drain the previous one.
   assign req_stall = at_check && rsp_valid;
   assign req_take  = req_valid && !req_stall;

   cfd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .take     (req_take),
      .rx_byte  (req_rx_byte),
      .at_check (at_check),
      .ack_req  (ack_req)
   );

   cfd_ack_tx u_ack_tx (
      .clock     (clock),
      .reset     (reset),
      .ack_req   (ack_req),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_byte  (rsp_tx_byte),
      .out_last  (rsp_tx_last)
   );

`ifndef SYNTH
   // A new reply never starts while the previous one is still going out.
   assert property (@(posedge clock) disable iff (reset) ack_req.fire |-> !rsp_valid)
      else $error("reply started while sender busy");

   // A started reply appears next cycle with the first header byte.
   assert property (@(posedge clock) disable iff (reset)
      ack_req.fire |=> (rsp_valid && (rsp_tx_byte == HDR_FIRST) && !rsp_tx_last))
      else $error("reply did not start with header");

   // Taking the final byte ends the burst.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_tx_last) |=> !rsp_valid)
      else $error("reply continued past final byte");
`endif

endmodule

`default_nettype wire

// ===== src/cfd_parser.sv =====
// Frame parser: tracks header, function, length, payload and checksum.
`default_nettype none

module cfd_parser
   import cfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        take,
   input  wire logic [7:0]  rx_byte,
   output logic             at_check,
   output ack_req_type      ack_req
);

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_HDR2  = 3'd1,
      PH_FUNC  = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHECK = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  left_ff, left_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  sum_plus;
   logic [5:0]  left_dec;

   assign sum_plus = sum_ff + rx_byte;
   assign left_dec = left_ff - 6'd1;

   always_comb begin
      phase_in      = phase_ff;
      left_in       = left_ff;
      sum_in        = sum_ff;
      func_in       = func_ff;
      ack_req.fire  = 1'b0;
      ack_req.func  = func_ff;
      ack_req.check = rx_byte;
      if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == HDR_FIRST) begin
                  phase_in = PH_HDR2;
                  sum_in   = rx_byte;
               end
            end
            PH_HDR2: begin
               if (rx_byte == HDR_SECOND) begin
                  phase_in = PH_FUNC;
                  sum_in   = sum_plus;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_FUNC: begin
               if (rx_byte < FUNC_LIMIT) begin
                  phase_in = PH_LEN;
                  func_in  = rx_byte;
                  sum_in   = sum_plus;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_LEN: begin
               if (rx_byte <= MAX_PAYLOAD) begin
                  phase_in = PH_DATA;
                  left_in  = rx_byte[5:0];
                  sum_in   = sum_plus;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_DATA: begin
               // A zero-length frame is dropped at the byte after its length.
               if (left_ff != 6'd0) begin
                  left_in = left_dec;
                  sum_in  = sum_plus;
                  if (left_dec == 6'd0) begin
                     phase_in = PH_CHECK;
                  end
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_CHECK: begin
               phase_in     = PH_HUNT;
               ack_req.fire = (rx_byte == sum_ff) && (func_ff >= GROUP_LO)
                              && (func_ff <= GROUP_HI);
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   assign at_check = (phase_ff == PH_CHECK);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         left_ff  <= 6'd0;
         sum_ff   <= 8'd0;
         func_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         sum_ff   <= sum_in;
         func_ff  <= func_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/cfd_ack_tx.sv =====
// Acknowledgement sender: serializes the seven-byte reply into an output register.
`default_nettype none

module cfd_ack_tx
   import cfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ack_req_type ack_req,
   input  wire logic        out_stall,
   output logic             out_valid,
   output logic [7:0]       out_byte,
   output logic             out_last
);

   logic        valid_ff, valid_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  check_ff, check_in;
   logic [7:0]  total_ff, total_in;
   logic        advance;

   assign advance = valid_ff && !out_stall;

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      func_in  = func_ff;
      check_in = check_ff;
      total_in = total_ff;
      if (ack_req.fire) begin
         valid_in = 1'b1;
         pos_in   = ACK_POS_HDR0;
         func_in  = ack_req.func;
         check_in = ack_req.check;
         total_in = ACK_SUM_BASE + ack_req.func + ack_req.check;
      end else if (advance) begin
         if (pos_ff == ACK_POS_SUM) begin
            valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end

      case (pos_in)
         ACK_POS_HDR0: byte_in = HDR_FIRST;
         ACK_POS_HDR1: byte_in = HDR_FIRST;
         ACK_POS_FUNC: byte_in = ACK_FUNC;
         ACK_POS_LEN:  byte_in = ACK_LEN;
         ACK_POS_CMD:  byte_in = func_in;
         ACK_POS_CHK:  byte_in = check_in;
         ACK_POS_SUM:  byte_in = total_in;
         default:      byte_in = total_in;
      endcase
      last_in = (pos_in == ACK_POS_SUM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= ACK_POS_HDR0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      func_ff  <= func_in;
      check_ff <= check_in;
      total_ff <= total_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// ===== sim/tb_command_frame_deframer_with_ack.sv =====
// Self-checking testbench for the command frame deframer and its acknowledgement replies.
`default_nettype none

module tb_command_frame_deframer_with_ack
   import cfd_pkg::*;
();

   // Parser phases as the block walks through one command frame.
   typedef enum logic [2:0] {
      HUNT_FIRST,
      WANT_SECOND,
      WANT_FUNC,
      WANT_LEN,
      IN_PAYLOAD,
      WANT_CHECK
   } parse_phase_type;

   // One byte of an acknowledgement frame as it leaves the block.
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } ack_beat_type;

   // Tracks the frame parser on every accepted request byte and keeps the
   // acknowledgement bytes that the block owes, oldest first.
   class ack_scoreboard;
      ack_beat_type    owed_q[$];
      parse_phase_type phase;
      logic [5:0]      bytes_left;
      logic [5:0]      payload_count;
      logic [7:0]      running_sum;
      logic [7:0]      function_code;
      int              errors;

      function new();
         phase           = HUNT_FIRST;
         bytes_left      = '0;
         payload_count   = '0;
         running_sum     = '0;
         function_code   = '0;
         errors          = 0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void note_request(logic [7:0] rx);
         logic [7:0] reply [0:6];
         logic [7:0] total;
         int         k;
         case (phase)
            HUNT_FIRST: begin
               if (rx == HDR_FIRST) begin
                  phase       = WANT_SECOND;
                  running_sum = rx;
               end
            end
            // Anything but the second header byte, even another first header
            // byte, drops the frame.
            WANT_SECOND: begin
               if (rx == HDR_SECOND) begin
                  phase       = WANT_FUNC;
                  running_sum = running_sum + rx;
               end else begin
                  phase = HUNT_FIRST;
               end
            end
            WANT_FUNC: begin
               if (rx < FUNC_LIMIT) begin
                  phase         = WANT_LEN;
                  function_code = rx;
                  running_sum   = running_sum + rx;
               end else begin
                  phase = HUNT_FIRST;
               end
            end
            WANT_LEN: begin
               if (rx <= MAX_PAYLOAD) begin
                  phase         = IN_PAYLOAD;
                  bytes_left    = rx[5:0];
                  payload_count = '0;
                  running_sum   = running_sum + rx;
               end else begin
                  phase = HUNT_FIRST;
               end
            end
            // A zero length arrives here with nothing left, so the frame is
            // abandoned on the byte after the length.
            IN_PAYLOAD: begin
               if (bytes_left != 0) begin
                  bytes_left    = bytes_left - 6'd1;
                  payload_count = payload_count + 6'd1;
                  running_sum   = running_sum + rx;
                  if (bytes_left == 0) begin
                     phase = WANT_CHECK;
                  end
               end else begin
                  phase = HUNT_FIRST;
               end
            end
            WANT_CHECK: begin
               phase = HUNT_FIRST;
               if (rx == running_sum && function_code >= GROUP_LO &&
                   function_code <= GROUP_HI) begin
                  reply[0] = HDR_FIRST;
                  reply[1] = HDR_FIRST;
                  reply[2] = ACK_FUNC;
                  reply[3] = ACK_LEN;
                  reply[4] = function_code;
                  reply[5] = rx;
                  total    = '0;
                  for (k = 0; k < 6; k++) begin
                     total = total + reply[k];
                  end
                  reply[6] = total;
                  for (k = 0; k < 7; k++) begin
                     owed_q.push_back('{tx_byte: reply[k], tx_last: (k == 6)});
                  end
               end
            end
            default: begin
               phase = HUNT_FIRST;
            end
         endcase
      endfunction

      function void check_reply(logic [7:0] tx_byte, logic tx_last);
         ack_beat_type want;
         if (owed_q.size() == 0) begin
            errors++;
            $display("%0t: reply with none owed: expected nothing, got tx_byte %02h tx_last %0b",
                     $time, tx_byte, tx_last);
            return;
         end
         want = owed_q.pop_front();
         if (tx_byte !== want.tx_byte) begin
            errors++;
            $display("%0t: tx_byte mismatch: expected %02h, got %02h",
                     $time, want.tx_byte, tx_byte);
         end
         if (tx_last !== want.tx_last) begin
            errors++;
            $display("%0t: tx_last mismatch: expected %0b, got %0b",
                     $time, want.tx_last, tx_last);
         end
      endfunction
   endclass

   // Hand-picked byte runs for the frame errors: header mismatch (a second
   // first-header byte), a function just past the limit, a length just past
   // the maximum, and a zero-length frame abandoned on the byte that follows.
   localparam int OPENING_LEN = 14;
   localparam logic [7:0] OPENING [0:OPENING_LEN-1] = '{
      8'hAA, 8'hAA,
      8'hAA, 8'hAF, 8'hF1,
      8'hAA, 8'hAF, 8'h10, 8'd50,
      8'hAA, 8'hAF, 8'h10, 8'h00, 8'hFF
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_tx_byte;
   logic       rsp_tx_last;

   ack_scoreboard sb;

   // Set near the end of the run to switch off idling on both sides.
   bit quiet;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit long_hold;
   int hold_cycles;
   // Frame bytes sent so far; plain noise bytes are not counted.
   int frame_items;

   command_frame_deframer_with_ack dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_tx_last (rsp_tx_last)
   );

   always #6 clock = ~clock;

   // Hard stop in case the block hangs or loses a reply.
   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

   // All ports are sampled at the rising edge, before any update from that
   // edge lands. The reply is checked before the request is noted, so a
   // reply can never match a request taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_reply(rsp_tx_byte, rsp_tx_last);
         end
         if (req_valid && !req_stall) begin
            sb.note_request(req_rx_byte);
         end
      end
   end

   // Receiver: random stall bursts between open stretches, plus one long hold-off
   // on request, counted here.
   initial begin
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            for (hold_cycles = 0; hold_cycles < 80; hold_cycles++) begin
               @(posedge clock);
            end
            long_hold = 1'b0;
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
      end
   end

   // Offers one request byte, maybe after a short idle burst, and returns at
   // the edge where the block takes it.
   task automatic send_byte(input logic [7:0] rx, input bit gaps_allowed);
      if (gaps_allowed && !quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_rx_byte <= rx;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Sends a whole frame with random payload; a bad frame gets its checksum
   // flipped by a nonzero mask.
   task automatic send_frame(input logic [7:0] func, input int len, input bit bad_check,
                             input bit gaps_allowed);
      logic [7:0] frame_q[$];
      logic [7:0] sum;
      int         k;
      frame_q = '{HDR_FIRST, HDR_SECOND, func, 8'(len)};
      for (k = 0; k < len; k++) begin
         frame_q.push_back(8'($urandom_range(0, 255)));
      end
      sum = '0;
      for (k = 0; k < frame_q.size(); k++) begin
         sum = sum + frame_q[k];
      end
      if (bad_check) begin
         sum = sum ^ 8'($urandom_range(1, 255));
      end
      frame_q.push_back(sum);
      for (k = 0; k < frame_q.size(); k++) begin
         send_byte(frame_q[k], gaps_allowed);
         frame_items++;
      end
   endtask

   // Mostly short payloads, now and then the longest one allowed.
   function automatic int pick_len();
      if ($urandom_range(0, 24) == 0) begin
         return MAX_PAYLOAD;
      end
      return $urandom_range(1, 6);
   endfunction

   function automatic logic [7:0] pick_group();
      return 8'($urandom_range(GROUP_LO, GROUP_HI));
   endfunction

   initial begin
      int  k;
      int  pick;
      bit  gaps;
      sb          = new();
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      rsp_stall   = 1'b0;
      quiet       = 1'b0;
      long_hold   = 1'b0;
      frame_items = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: the frame errors, then a good group frame with a
      // one-byte payload, a good frame with the highest function outside the
      // groups, and a group frame with a broken checksum.
      for (k = 0; k < OPENING_LEN; k++) begin
         send_byte(OPENING[k], 1'b1);
      end
      send_frame(GROUP_LO, 1, 1'b0, 1'b1);
      send_frame(8'hF0, 1, 1'b0, 1'b1);
      send_frame(GROUP_HI, 1, 1'b1, 1'b1);

      // The receiver holds off for a long while as good group frames keep
      // coming, so the pending reply backs up into the request side.
      long_hold = 1'b1;
      for (k = 0; k < 4; k++) begin
         send_frame(pick_group(), $urandom_range(1, 4), 1'b0, 1'b0);
      end

      // Random part: mostly well-formed frames with random content, the rest
      // broken frames and line noise.
      while (frame_items < 170) begin
         if (frame_items >= 140) begin
            quiet = 1'b1;
         end
         gaps = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_frame(pick_group(), pick_len(), 1'b0, gaps);
         end else if (pick < 65) begin
            send_frame(8'($urandom_range(0, FUNC_LIMIT - 1)), pick_len(), 1'b0, gaps);
         end else if (pick < 73) begin
            send_frame(pick_group(), pick_len(), 1'b1, gaps);
         end else if (pick < 76) begin
            // Header mismatch on a random second byte.
            send_byte(HDR_FIRST, gaps);
            send_byte(8'($urandom_range(0, 255)), gaps);
            frame_items += 2;
         end else if (pick < 79) begin
            // Function byte at or past the limit.
            send_byte(HDR_FIRST, gaps);
            send_byte(HDR_SECOND, gaps);
            send_byte(8'($urandom_range(FUNC_LIMIT, 255)), gaps);
            frame_items += 3;
         end else if (pick < 82) begin
            // Length byte past the maximum.
            send_byte(HDR_FIRST, gaps);
            send_byte(HDR_SECOND, gaps);
            send_byte(pick_group(), gaps);
            send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)), gaps);
            frame_items += 4;
         end else if (pick < 85) begin
            // Zero-length frame and the byte it is abandoned on.
            send_byte(HDR_FIRST, gaps);
            send_byte(HDR_SECOND, gaps);
            send_byte(pick_group(), gaps);
            send_byte(8'h00, gaps);
            send_byte(8'($urandom_range(0, 255)), gaps);
            frame_items += 5;
         end else if (pick < 89) begin
            // A frame cut short; the next frame's bytes land in its payload.
            send_byte(HDR_FIRST, gaps);
            send_byte(HDR_SECOND, gaps);
            send_byte(pick_group(), gaps);
            send_byte(8'($urandom_range(1, 8)), gaps);
            frame_items += 4;
         end else begin
            repeat ($urandom_range(1, 5)) begin
               send_byte(8'($urandom_range(0, 255)), gaps);
            end
         end
      end
      req_valid <= 1'b0;

      // Drain the owed replies, then watch a little longer for strays.
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
src/cfd_pkg.sv
src/cfd_parser.sv
src/cfd_ack_tx.sv
src/command_frame_deframer_with_ack.sv
sim/tb_command_frame_deframer_with_ack.sv
